// File: design/tsep_pkg.sv
// Shared types and constants for the timestamp event postprocessor.
`default_nettype none

package tsep_pkg;

  localparam int unsigned WordWidth  = 32;
  localparam int unsigned EventWidth = 64;
  localparam int unsigned CountWidth = 31;
  localparam int unsigned ModeWidth  = 2;
  localparam int unsigned AddrWidth  = 2;
  localparam int unsigned CfgWidth   = 64;

  localparam logic [AddrWidth-1:0] RegOutputMode = 2'd0;
  localparam logic [AddrWidth-1:0] RegSwapHalves = 2'd1;
  localparam logic [AddrWidth-1:0] RegEventLimit = 2'd2;
  localparam logic [AddrWidth-1:0] RegTimeOffset = 2'd3;

  localparam logic [ModeWidth-1:0] ModeRaw       = 2'd0;
  localparam logic [ModeWidth-1:0] ModeSwappable = 2'd1;

  typedef struct packed {
    logic [ModeWidth-1:0]  output_mode;
    logic                  swap_halves;
    logic [CountWidth-1:0] event_limit;
    logic [EventWidth-1:0] time_offset;
  } cfg_t;

endpackage

`default_nettype wire

// File: design/timestamp_event_postprocessor.sv
// Top level of the timestamp event postprocessor.
//
// Input channel: one 32-bit readback word per item (stream_word_i), valid/stall.
// Even words are low halves, odd words high halves of a 64-bit event.
// Output channel: event_data_o, is_raw_o, limit_reached_o, valid/stall.
// Raw mode emits every word; processed modes emit one item per nonzero pair,
// offset-corrected and optionally half-swapped in mode 1.
// Config: write-only port (cfg_we_i, cfg_addr_i, cfg_wdata_i), written while idle.
// An accepted word is held in the input register; its result is registered in
// the result register that drives the outputs. Throughput: one word per cycle
// unless the receiver stalls, set by the input/result register pair around the 64-bit adder.
// Once the event limit is reached all further words are dropped until reset.
// Reset clears the config, the pair position, the event count and the halt.
// When the receiver stalls, the result register holds; one more word is taken
// into the input register if it is empty, then in_stall_o rises until the result is taken.
`default_nettype none

module timestamp_event_postprocessor (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic [tsep_pkg::WordWidth-1:0]  stream_word_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic [tsep_pkg::EventWidth-1:0]      event_data_o,
  output logic                                 is_raw_o,
  output logic                                 limit_reached_o,
  input  wire logic                            cfg_we_i,
  input  wire logic [tsep_pkg::AddrWidth-1:0]  cfg_addr_i,
  input  wire logic [tsep_pkg::CfgWidth-1:0]   cfg_wdata_i
);

  tsep_pkg::cfg_t cfg;

  tsep_cfg_regs u_cfg_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_addr_i (cfg_addr_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cfg_o      (cfg)
  );

  logic                             s1_valid_q, s1_valid_d;
  logic [tsep_pkg::WordWidth-1:0]   s1_word_q, s1_word_d;
  logic [tsep_pkg::WordWidth-1:0]   low_q, low_d;
  logic                             have_q, have_d;
  logic [tsep_pkg::CountWidth-1:0]  count_q, count_d;
  logic                             halted_q, halted_d;
  logic                             out_valid_q, out_valid_d;
  logic [tsep_pkg::EventWidth-1:0]  data_q, data_d;
  logic                             raw_q, raw_d;
  logic                             hit_q, hit_d;

  logic                             out_ready;
  logic                             process;
  logic [tsep_pkg::EventWidth-1:0]  pair;
  logic [tsep_pkg::EventWidth-1:0]  sum;
  logic [tsep_pkg::CountWidth-1:0]  count_inc;
  logic                             limit_on;
  logic                             hit_c;
  logic                             emit;

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !out_ready;
  assign process    = s1_valid_q && out_ready && !halted_q;

  assign pair      = {s1_word_q, low_q};
  assign sum       = pair + cfg.time_offset;
  assign count_inc = count_q + tsep_pkg::CountWidth'(1);
  assign limit_on  = cfg.event_limit != '0;
  assign hit_c     = limit_on && (count_inc >= cfg.event_limit);

  always_comb begin
    low_d    = low_q;
    have_d   = have_q;
    count_d  = count_q;
    halted_d = halted_q;
    emit     = 1'b0;
    data_d   = data_q;
    raw_d    = raw_q;
    hit_d    = hit_q;
    if (process) begin
      if (cfg.output_mode == tsep_pkg::ModeRaw) begin
        emit   = 1'b1;
        data_d = {{(tsep_pkg::EventWidth-tsep_pkg::WordWidth){1'b0}}, s1_word_q};
        raw_d  = 1'b1;
        hit_d  = 1'b0;
        if (have_q) begin
          have_d = 1'b0;
          if (limit_on) begin
            count_d  = count_inc;
            halted_d = hit_c;
            hit_d    = hit_c;
          end
        end else begin
          low_d  = s1_word_q;
          have_d = 1'b1;
        end
      end else if (!have_q) begin
        low_d  = s1_word_q;
        have_d = 1'b1;
      end else begin
        have_d = 1'b0;
        if (pair != '0) begin
          emit  = 1'b1;
          raw_d = 1'b0;
          hit_d = 1'b0;
          if (cfg.output_mode == tsep_pkg::ModeSwappable && cfg.swap_halves) begin
            data_d = {sum[tsep_pkg::WordWidth-1:0],
                      sum[tsep_pkg::EventWidth-1:tsep_pkg::WordWidth]};
          end else begin
            data_d = sum;
          end
          if (limit_on) begin
            count_d  = count_inc;
            halted_d = hit_c;
            hit_d    = hit_c;
          end
        end
      end
    end
  end

  always_comb begin
    s1_valid_d  = s1_valid_q;
    s1_word_d   = s1_word_q;
    out_valid_d = out_valid_q;
    if (!in_stall_o) begin
      s1_valid_d = in_valid_i;
      if (in_valid_i) begin
        s1_word_d = stream_word_i;
      end
    end
    if (out_ready) begin
      out_valid_d = emit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      have_q      <= 1'b0;
      count_q     <= '0;
      halted_q    <= 1'b0;
      out_valid_q <= 1'b0;
      low_q       <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      have_q      <= have_d;
      count_q     <= count_d;
      halted_q    <= halted_d;
      out_valid_q <= out_valid_d;
      low_q       <= low_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_word_q <= s1_word_d;
    data_q    <= data_d;
    raw_q     <= raw_d;
    hit_q     <= hit_d;
  end

  assign out_valid_o     = out_valid_q;
  assign event_data_o    = data_q;
  assign is_raw_o        = raw_q;
  assign limit_reached_o = hit_q;

endmodule

`default_nettype wire

// File: design/tsep_cfg_regs.sv
// Configuration register file for the timestamp event postprocessor.
`default_nettype none

module tsep_cfg_regs (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [tsep_pkg::AddrWidth-1:0] cfg_addr_i,
  input  wire logic [tsep_pkg::CfgWidth-1:0]  cfg_wdata_i,
  output tsep_pkg::cfg_t                      cfg_o
);

  tsep_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        tsep_pkg::RegOutputMode: begin
          cfg_q.output_mode <= cfg_wdata_i[tsep_pkg::ModeWidth-1:0];
        end
        tsep_pkg::RegSwapHalves: begin
          cfg_q.swap_halves <= cfg_wdata_i[0];
        end
        tsep_pkg::RegEventLimit: begin
          cfg_q.event_limit <= cfg_wdata_i[tsep_pkg::CountWidth-1:0];
        end
        tsep_pkg::RegTimeOffset: begin
          cfg_q.time_offset <= cfg_wdata_i[tsep_pkg::EventWidth-1:0];
        end
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// File: design/tsep_checker.sv
// Port-level assertions for the timestamp event postprocessor, with bind.
`default_nettype none

module tsep_checker (
  input wire logic                            clk_i,
  input wire logic                            rst_ni,
  input wire logic                            in_stall_o,
  input wire logic                            out_valid_o,
  input wire logic                            out_stall_i,
  input wire logic [tsep_pkg::EventWidth-1:0] event_data_o,
  input wire logic                            is_raw_o,
  input wire logic                            limit_reached_o
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(event_data_o)
      && $stable(is_raw_o) && $stable(limit_reached_o))
    else $error("stalled result changed");

  // input only backs up behind a stalled result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output backpressure");

  // nothing follows the item that reaches the limit
  a_halt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && limit_reached_o |=> !out_valid_o)
    else $error("item after limit reached");

  // raw items are zero-extended words
  a_raw_width: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_raw_o |-> event_data_o[63:32] == 32'h0)
    else $error("raw item has nonzero upper half");

endmodule

bind timestamp_event_postprocessor tsep_checker u_tsep_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .event_data_o   (event_data_o),
  .is_raw_o       (is_raw_o),
  .limit_reached_o(limit_reached_o)
);

`default_nettype wire

// File: tb/sv/tb_top.sv
// Self-checking testbench for the timestamp event postprocessor.
module tb_top;

  localparam logic [tsep_pkg::ModeWidth-1:0]  ModeEvents   = 2'd2;
  localparam logic [tsep_pkg::ModeWidth-1:0]  ModeSpare    = 2'd3;
  localparam logic [tsep_pkg::CountWidth-1:0] CountMax     = '1;
  localparam int                              TotalWords   = 1250;
  localparam int                              SettleCycles = 6;
  localparam int                              CycleLimit   = 400000;

  typedef struct packed {
    logic [tsep_pkg::EventWidth-1:0] data;
    logic                            raw;
    logic                            reached;
  } event_rec_t;

  class event_tracker;
    logic [tsep_pkg::ModeWidth-1:0]  mode;
    logic                            swap;
    logic [tsep_pkg::CountWidth-1:0] limit;
    logic [tsep_pkg::EventWidth-1:0] offset;
    logic [tsep_pkg::WordWidth-1:0]  held_low;
    logic                            low_held;
    logic [tsep_pkg::CountWidth-1:0] counted;
    logic                            halted;
    event_rec_t                      pending_events[$];
    int                              mismatches;

    function new();
      mode       = tsep_pkg::ModeRaw;
      swap       = 1'b0;
      limit      = '0;
      offset     = '0;
      held_low   = '0;
      low_held   = 1'b0;
      counted    = '0;
      halted     = 1'b0;
      mismatches = 0;
    endfunction

    function void set_config(input logic [tsep_pkg::ModeWidth-1:0] m, input logic s,
                             input logic [tsep_pkg::CountWidth-1:0] l,
                             input logic [tsep_pkg::EventWidth-1:0] o);
      mode   = m;
      swap   = s;
      limit  = l;
      offset = o;
    endfunction

    function logic bump_count();
      if (limit == '0) return 1'b0;
      counted = counted + 1'b1;
      if (counted >= limit) begin
        halted = 1'b1;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function void take_word(input logic [tsep_pkg::WordWidth-1:0] w);
      event_rec_t                      rec;
      logic [tsep_pkg::EventWidth-1:0] ev;
      if (halted) return;
      if (mode == tsep_pkg::ModeRaw) begin
        rec.reached = 1'b0;
        if (low_held) begin
          low_held    = 1'b0;
          rec.reached = bump_count();
        end else begin
          held_low = w;
          low_held = 1'b1;
        end
        rec.data = {{(tsep_pkg::EventWidth-tsep_pkg::WordWidth){1'b0}}, w};
        rec.raw  = 1'b1;
        pending_events.push_back(rec);
        return;
      end
      if (!low_held) begin
        held_low = w;
        low_held = 1'b1;
        return;
      end
      low_held = 1'b0;
      ev = {w, held_low};
      if (ev == '0) return;
      ev = ev + offset;
      if (mode == tsep_pkg::ModeSwappable && swap) ev = {ev[31:0], ev[63:32]};
      rec.reached = bump_count();
      rec.data    = ev;
      rec.raw     = 1'b0;
      pending_events.push_back(rec);
    endfunction

    function void match_event(input logic [tsep_pkg::EventWidth-1:0] data, input logic raw,
                              input logic reached);
      event_rec_t want;
      if (pending_events.size() == 0) begin
        $display("%0t: unexpected item: event_data %h is_raw %0b limit_reached %0b",
                 $time, data, raw, reached);
        mismatches++;
        return;
      end
      want = pending_events.pop_front();
      if (want.data !== data) begin
        $display("%0t: event_data expected %h actual %h", $time, want.data, data);
        mismatches++;
      end
      if (want.raw !== raw) begin
        $display("%0t: is_raw expected %0b actual %0b", $time, want.raw, raw);
        mismatches++;
      end
      if (want.reached !== reached) begin
        $display("%0t: limit_reached expected %0b actual %0b", $time, want.reached, reached);
        mismatches++;
      end
    endfunction

    function int waiting();
      return pending_events.size();
    endfunction
  endclass

  logic                            clk_i;
  logic                            rst_ni        = 1'b0;
  logic                            in_valid_i    = 1'b0;
  logic                            in_stall_o;
  logic [tsep_pkg::WordWidth-1:0]  stream_word_i = '0;
  logic                            out_valid_o;
  logic                            out_stall_i   = 1'b0;
  logic [tsep_pkg::EventWidth-1:0] event_data_o;
  logic                            is_raw_o;
  logic                            limit_reached_o;
  logic                            cfg_we_i      = 1'b0;
  logic [tsep_pkg::AddrWidth-1:0]  cfg_addr_i    = '0;
  logic [tsep_pkg::CfgWidth-1:0]   cfg_wdata_i   = '0;

  event_tracker tracker;
  int           words_sent   = 0;
  int           tx_idle_pct  = 19;
  int           rx_idle_pct  = 88;
  int           hold_request = 0;
  int           hold_left    = 0;
  int           cycles       = 0;

  timestamp_event_postprocessor u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .stream_word_i  (stream_word_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .event_data_o   (event_data_o),
    .is_raw_o       (is_raw_o),
    .limit_reached_o(limit_reached_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_addr_i     (cfg_addr_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("tb_top: FAIL");
    $finish;
  end

  // Receiver: check taken items, then pick the stall for the next cycle.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      tracker.match_event(event_data_o, is_raw_o, limit_reached_o);
    end
    if (hold_request > 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else begin
      out_stall_i <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  function automatic logic [tsep_pkg::WordWidth-1:0] pick_word();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2: return 32'h1 << $urandom_range(31);
      3: return ~(32'h1 << $urandom_range(31));
      default: return $urandom();
    endcase
  endfunction

  task automatic send_word(input logic [tsep_pkg::WordWidth-1:0] w);
    int gap;
    gap = 0;
    case (words_sent * 3 / TotalWords)
      0: begin
        tx_idle_pct = 19;
        rx_idle_pct = 88;
      end
      1: begin
        tx_idle_pct = 88;
        rx_idle_pct = 19;
      end
      default: begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
    endcase
    while ($urandom_range(99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    stream_word_i <= w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    tracker.take_word(w);
    words_sent++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (tracker.waiting() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic apply_config(input logic [tsep_pkg::ModeWidth-1:0] m, input logic s,
                              input logic [tsep_pkg::CountWidth-1:0] l,
                              input logic [tsep_pkg::EventWidth-1:0] o);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= tsep_pkg::RegOutputMode;
    cfg_wdata_i <= tsep_pkg::CfgWidth'(m);
    @(posedge clk_i);
    cfg_addr_i  <= tsep_pkg::RegSwapHalves;
    cfg_wdata_i <= tsep_pkg::CfgWidth'(s);
    @(posedge clk_i);
    cfg_addr_i  <= tsep_pkg::RegEventLimit;
    cfg_wdata_i <= tsep_pkg::CfgWidth'(l);
    @(posedge clk_i);
    cfg_addr_i  <= tsep_pkg::RegTimeOffset;
    cfg_wdata_i <= o;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    tracker.set_config(m, s, l, o);
  endtask

  initial begin
    int                              n;
    int                              phase;
    logic                            zero_pair;
    logic [tsep_pkg::CountWidth-1:0] lim;
    logic [tsep_pkg::EventWidth-1:0] ofs;
    tracker = new();
    zero_pair = 1'b0;
    phase = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // raw words with pair counting; last word leaves a low half held
    apply_config(tsep_pkg::ModeRaw, 1'b0, CountMax, '0);
    send_word('0);
    send_word('1);
    send_word(32'h1);
    send_word(32'h8000_0000);
    send_word(32'h1234_5678);
    // mode change mid-pair, swap, offset wrap, dropped zero event
    drain();
    apply_config(tsep_pkg::ModeSwappable, 1'b1, CountMax, '1);
    send_word(32'hdead_beef);
    send_word('0);
    send_word('0);
    send_word('1);
    send_word('1);
    // swap ignored outside mode 1, unlimited, event that wraps to zero
    drain();
    apply_config(ModeEvents, 1'b1, '0, 64'h1);
    send_word(32'h5);
    send_word('0);
    send_word('0);
    send_word('0);
    send_word('1);
    send_word('1);
    drain();
    apply_config(ModeSpare, 1'b0, '0, {$urandom(), $urandom()});
    repeat (4) send_word(pick_word());

    while (words_sent < TotalWords) begin
      drain();
      case ($urandom_range(3))
        0: lim = '0;
        1: lim = CountMax;
        default: lim = tsep_pkg::CountWidth'($urandom_range(CountMax, 2000));
      endcase
      case ($urandom_range(3))
        0: ofs = '0;
        1: ofs = '1;
        default: ofs = {$urandom(), $urandom()};
      endcase
      if (phase == 0) begin
        apply_config(tsep_pkg::ModeRaw, 1'($urandom_range(1)), lim, ofs);
        hold_request = 300;
      end else begin
        apply_config(2'($urandom_range(3)), 1'($urandom_range(1)), lim, ofs);
        if ($urandom_range(3) == 0) hold_request = $urandom_range(300, 100);
      end
      n = $urandom_range(160, 20);
      for (int i = 0; i < n; i++) begin
        if (!tracker.low_held) zero_pair = ($urandom_range(9) == 0);
        send_word(zero_pair ? '0 : pick_word());
      end
      phase++;
    end

    // limit written below the count: the next counted event halts the block
    drain();
    apply_config(2'($urandom_range(3)), 1'($urandom_range(1)), 31'd1,
                 {$urandom(), $urandom()});
    repeat (40) send_word(pick_word());

    drain();
    if (tracker.mismatches == 0 && tracker.waiting() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

// File: timestamp_event_postprocessor.f
design/tsep_pkg.sv
design/tsep_cfg_regs.sv
design/timestamp_event_postprocessor.sv
design/tsep_checker.sv
tb/sv/tb_top.sv
